// File: rtl/mcnt_pkg.sv
// ----------------------------------------------------------------------------
// mcnt_pkg
// Types and constants shared by the MIDI channel message note tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package mcnt_pkg;

  localparam int unsigned NumChannels     = 16;
  localparam int unsigned NotesPerChannel = 128;
  localparam int unsigned ChanW           = $clog2(NumChannels);
  localparam int unsigned NoteW           = $clog2(NotesPerChannel);

  localparam logic [3:0] StatusNoteOff   = 4'h8;
  localparam logic [3:0] StatusNoteOn    = 4'h9;
  localparam logic [3:0] StatusKeyPress  = 4'hA;
  localparam logic [3:0] StatusControl   = 4'hB;
  localparam logic [3:0] StatusProgram   = 4'hC;
  localparam logic [3:0] StatusChanPress = 4'hD;
  localparam logic [3:0] StatusBend      = 4'hE;

  localparam logic [1:0] LenNone  = 2'd0;
  localparam logic [1:0] LenShort = 2'd2;
  localparam logic [1:0] LenLong  = 2'd3;

  typedef enum logic [2:0] {
    KIND_NOTE_OFF   = 3'd0,
    KIND_NOTE_ON    = 3'd1,
    KIND_KEY_PRESS  = 3'd2,
    KIND_CONTROL    = 3'd3,
    KIND_PROGRAM    = 3'd4,
    KIND_CHAN_PRESS = 3'd5,
    KIND_BEND       = 3'd6,
    KIND_UNKNOWN    = 3'd7
  } kind_e;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [6:0] data_one;
    logic [6:0] data_two;
  } in_item_t;

  typedef struct packed {
    logic [2:0] msg_kind;
    logic [3:0] channel_out;
    logic [6:0] first_value;
    logic [6:0] second_value;
    logic [1:0] msg_length;
    logic       was_active;
    logic       now_active;
  } out_item_t;

  // decoder result handed to the top level and the bitmap
  typedef struct packed {
    kind_e      kind;
    logic [1:0] length;
    logic [3:0] channel;
    logic [6:0] value_two;
    logic       is_note;
    logic       note_on;
  } decode_t;

endpackage

`default_nettype wire

// File: rtl/mcnt_if.sv
// ----------------------------------------------------------------------------
// mcnt_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcnt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] status_byte;
  logic [6:0] data_one;
  logic [6:0] data_two;

  modport source (output valid, output status_byte, output data_one,
                  output data_two, input ready);
  modport sink   (input valid, input status_byte, input data_one,
                  input data_two, output ready);
endinterface

interface mcnt_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] msg_kind;
  logic [3:0] channel_out;
  logic [6:0] first_value;
  logic [6:0] second_value;
  logic [1:0] msg_length;
  logic       was_active;
  logic       now_active;

  modport source (output valid, output msg_kind, output channel_out,
                  output first_value, output second_value, output msg_length,
                  output was_active, output now_active, input ready);
  modport sink   (input valid, input msg_kind, input channel_out,
                  input first_value, input second_value, input msg_length,
                  input was_active, input now_active, output ready);
endinterface

`default_nettype wire

// File: rtl/mcnt_decode.sv
// ----------------------------------------------------------------------------
// mcnt_decode
// Status byte decoder: message kind, length, channel and note control.
// ----------------------------------------------------------------------------
`default_nettype none

module mcnt_decode
  import mcnt_pkg::*;
(
  input  wire logic [7:0] status_i,
  input  wire logic [6:0] data_two_i,
  output decode_t         dec_o
);

  logic vel_nonzero;
  assign vel_nonzero = (data_two_i != 7'd0);

  always_comb begin
    dec_o.kind      = KIND_UNKNOWN;
    dec_o.length    = LenNone;
    dec_o.is_note   = 1'b0;
    dec_o.note_on   = 1'b0;
    unique case (status_i[7:4])
      StatusNoteOff: begin
        dec_o.kind    = KIND_NOTE_OFF;
        dec_o.length  = LenLong;
        dec_o.is_note = 1'b1;
      end
      StatusNoteOn: begin
        dec_o.kind    = vel_nonzero ? KIND_NOTE_ON : KIND_NOTE_OFF;
        dec_o.length  = LenLong;
        dec_o.is_note = 1'b1;
        dec_o.note_on = vel_nonzero;
      end
      StatusKeyPress: begin
        dec_o.kind   = KIND_KEY_PRESS;
        dec_o.length = LenLong;
      end
      StatusControl: begin
        dec_o.kind   = KIND_CONTROL;
        dec_o.length = LenLong;
      end
      StatusProgram: begin
        dec_o.kind   = KIND_PROGRAM;
        dec_o.length = LenShort;
      end
      StatusChanPress: begin
        dec_o.kind   = KIND_CHAN_PRESS;
        dec_o.length = LenShort;
      end
      StatusBend: begin
        dec_o.kind   = KIND_BEND;
        dec_o.length = LenLong;
      end
      default: begin
        dec_o.kind   = KIND_UNKNOWN;
        dec_o.length = LenNone;
      end
    endcase
    dec_o.channel   = (dec_o.kind == KIND_UNKNOWN) ? 4'd0 : status_i[3:0];
    dec_o.value_two = (dec_o.length == LenLong) ? data_two_i : 7'd0;
  end

endmodule

`default_nettype wire

// File: rtl/mcnt_bitmap.sv
// ----------------------------------------------------------------------------
// mcnt_bitmap
// Active-note bitmap: one 128-bit row per channel, row valid flags cleared
// at reset, registered row read and one-deep write forwarding.
// ----------------------------------------------------------------------------
`default_nettype none

module mcnt_bitmap
  import mcnt_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             rd_en_i,
  input  wire logic [ChanW-1:0] rd_chan_i,
  input  wire logic             wr_en_i,
  input  wire logic [ChanW-1:0] cur_chan_i,
  input  wire logic [NoteW-1:0] cur_note_i,
  input  wire logic             cur_set_i,
  output logic                  was_bit_o
);

  logic [NotesPerChannel-1:0] mem [NumChannels];
  logic [NumChannels-1:0]     row_vld_q;
  logic [NotesPerChannel-1:0] rd_row_q;
  logic                       rd_vld_q;
  logic [NotesPerChannel-1:0] fwd_row_q;
  logic [ChanW-1:0]           fwd_chan_q;
  logic                       fwd_vld_q;
  logic [NotesPerChannel-1:0] cur_row;
  logic [NotesPerChannel-1:0] new_row;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_row_q <= mem[rd_chan_i];
    end
    if (wr_en_i) begin
      mem[cur_chan_i] <= new_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
      fwd_vld_q <= 1'b0;
    end else begin
      if (rd_en_i) begin
        rd_vld_q <= row_vld_q[rd_chan_i];
      end
      if (wr_en_i) begin
        row_vld_q[cur_chan_i] <= 1'b1;
        fwd_vld_q             <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      fwd_row_q  <= new_row;
      fwd_chan_q <= cur_chan_i;
    end
  end

  always_comb begin
    if (fwd_vld_q && (fwd_chan_q == cur_chan_i)) begin
      cur_row = fwd_row_q;
    end else if (rd_vld_q) begin
      cur_row = rd_row_q;
    end else begin
      cur_row = '0;
    end
    new_row             = cur_row;
    new_row[cur_note_i] = cur_set_i;
  end

  assign was_bit_o = cur_row[cur_note_i];

endmodule

`default_nettype wire

// File: rtl/midi_channel_message_note_tracker_core.sv
// ----------------------------------------------------------------------------
// midi_channel_message_note_tracker_core
// An accepted input item loads the input register, then the result register
// drives result valid.
// Throughput: one item per cycle; a stalled result holds the input register.
// Reset: asynchronous, clears pipeline valids and the per-channel row flags,
// so the active-note bitmap reads all zero at once; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_channel_message_note_tracker_core
  import mcnt_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mcnt_in_if.sink    in_i,
  mcnt_out_if.source out_o
);

  in_item_t  s1_q;
  logic      s1_vld_q;
  out_item_t out_q, out_d;
  logic      out_vld_q;
  logic      advance;
  logic      accept;
  decode_t   dec;
  logic      was_bit;

  assign advance    = s1_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !s1_vld_q || advance;
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_vld_q <= 1'b1;
      end else if (advance) begin
        s1_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.status_byte <= in_i.status_byte;
      s1_q.data_one    <= in_i.data_one;
      s1_q.data_two    <= in_i.data_two;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  mcnt_decode u_decode (
    .status_i   (s1_q.status_byte),
    .data_two_i (s1_q.data_two),
    .dec_o      (dec)
  );

  mcnt_bitmap u_bitmap (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_chan_i  (in_i.status_byte[3:0]),
    .wr_en_i    (advance && dec.is_note),
    .cur_chan_i (s1_q.status_byte[3:0]),
    .cur_note_i (s1_q.data_one),
    .cur_set_i  (dec.note_on),
    .was_bit_o  (was_bit)
  );

  always_comb begin
    out_d.msg_kind     = dec.kind;
    out_d.channel_out  = dec.channel;
    out_d.first_value  = (dec.kind == KIND_UNKNOWN) ? 7'd0 : s1_q.data_one;
    out_d.second_value = dec.value_two;
    out_d.msg_length   = dec.length;
    out_d.was_active   = dec.is_note && was_bit;
    out_d.now_active   = dec.is_note && dec.note_on;
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.msg_kind     = out_q.msg_kind;
  assign out_o.channel_out  = out_q.channel_out;
  assign out_o.first_value  = out_q.first_value;
  assign out_o.second_value = out_q.second_value;
  assign out_o.msg_length   = out_q.msg_length;
  assign out_o.was_active   = out_q.was_active;
  assign out_o.now_active   = out_q.now_active;

endmodule

`default_nettype wire

// File: sim/midi_channel_message_note_tracker_core_checker.sv
// ----------------------------------------------------------------------------
// midi_channel_message_note_tracker_core_checker
// Watches both channels of the note tracker, predicts the decoded message and
// the active-note bitmap update for every accepted item, and compares each
// accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module midi_channel_message_note_tracker_core_checker
  import mcnt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  mcnt_in_if          in_mon,
  mcnt_out_if         out_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic      note_held [NumChannels * NotesPerChannel];
  out_item_t decoded_q [$];

  function automatic out_item_t decode_message(in_item_t msg);
    out_item_t res;
    kind_e     kind;
    logic [1:0] len;
    logic [ChanW+NoteW-1:0] slot;
    res  = '0;
    kind = KIND_UNKNOWN;
    len  = LenNone;
    slot = {msg.status_byte[3:0], msg.data_one};
    case (msg.status_byte[7:4])
      StatusNoteOff: begin
        kind = KIND_NOTE_OFF;
        len  = LenLong;
      end
      StatusNoteOn: begin
        kind = (msg.data_two != '0) ? KIND_NOTE_ON : KIND_NOTE_OFF;
        len  = LenLong;
      end
      StatusKeyPress: begin
        kind = KIND_KEY_PRESS;
        len  = LenLong;
      end
      StatusControl: begin
        kind = KIND_CONTROL;
        len  = LenLong;
      end
      StatusProgram: begin
        kind = KIND_PROGRAM;
        len  = LenShort;
      end
      StatusChanPress: begin
        kind = KIND_CHAN_PRESS;
        len  = LenShort;
      end
      StatusBend: begin
        kind = KIND_BEND;
        len  = LenLong;
      end
      default: begin
        kind = KIND_UNKNOWN;
        len  = LenNone;
      end
    endcase
    res.msg_kind   = kind;
    res.msg_length = len;
    if (kind != KIND_UNKNOWN) begin
      res.channel_out  = msg.status_byte[3:0];
      res.first_value  = msg.data_one;
      res.second_value = (len == LenLong) ? msg.data_two : '0;
      if (kind == KIND_NOTE_OFF || kind == KIND_NOTE_ON) begin
        res.was_active  = note_held[slot];
        note_held[slot] = (kind == KIND_NOTE_ON);
        res.now_active  = note_held[slot];
      end
    end
    return res;
  endfunction

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      fail_count_o++;
    end
  endtask

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    out_item_t got;
    if (!rst_ni) begin
      decoded_q.delete();
      foreach (note_held[i]) note_held[i] = 1'b0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.msg_kind, out_mon.channel_out, out_mon.first_value,
                out_mon.second_value, out_mon.msg_length, out_mon.was_active,
                out_mon.now_active};
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected result item, expected none, got %h", $time, got);
          fail_count_o++;
        end else begin
          want = decoded_q.pop_front();
          check_field("msg_kind", want.msg_kind, got.msg_kind);
          check_field("channel_out", want.channel_out, got.channel_out);
          check_field("first_value", want.first_value, got.first_value);
          check_field("second_value", want.second_value, got.second_value);
          check_field("msg_length", want.msg_length, got.msg_length);
          check_field("was_active", want.was_active, got.was_active);
          check_field("now_active", want.now_active, got.now_active);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        decoded_q.push_back(decode_message('{in_mon.status_byte, in_mon.data_one,
                                             in_mon.data_two}));
      end
    end
    pending_o = decoded_q.size();
  end

endmodule

// File: sim/midi_channel_message_note_tracker_core_test.sv
// ----------------------------------------------------------------------------
// midi_channel_message_note_tracker_core_test
// Drives directed and random MIDI channel messages into the note tracker with
// random source gaps and sink stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module midi_channel_message_note_tracker_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mcnt_pkg::*;

  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned ItemsPerPhase = 550;

  logic        clk_i;
  logic        rst_ni;
  int unsigned sender_idle;
  int unsigned receiver_idle;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles;

  mcnt_in_if  in_if ();
  mcnt_out_if out_if ();

  midi_channel_message_note_tracker_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  midi_channel_message_note_tracker_core_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= receiver_idle);
  end

  task automatic send_message(input logic [7:0] status, input logic [6:0] d1,
                              input logic [6:0] d2);
    while ($urandom_range(99) < sender_idle) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.status_byte <= status;
    in_if.data_one    <= d1;
    in_if.data_two    <= d2;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  // note messages mostly hit a small pool of notes so bits get set and cleared
  function automatic in_item_t make_message();
    in_item_t   msg;
    int unsigned pick;
    int unsigned u;
    logic [3:0] upper;
    logic [3:0] chan;
    logic       hot;
    pick = $urandom_range(99);
    hot  = ($urandom_range(3) != 0);
    chan = hot ? 4'($urandom_range(3) * 5) : 4'($urandom_range(15));
    msg.data_one = hot ? 7'(60 + $urandom_range(7)) : 7'($urandom_range(127));
    msg.data_two = 7'($urandom_range(127));
    if (pick < 35) begin
      upper = StatusNoteOn;
      if ($urandom_range(7) == 0) msg.data_two = '0;
    end else if (pick < 60) begin
      upper = StatusNoteOff;
    end else if (pick < 88) begin
      upper = 4'(StatusKeyPress + $urandom_range(4));
      chan  = 4'($urandom_range(15));
      msg.data_one = 7'($urandom_range(127));
    end else begin
      u     = $urandom_range(8);
      upper = (u == 8) ? 4'hF : 4'(u);
      chan  = 4'($urandom_range(15));
    end
    msg.status_byte = {upper, chan};
    return msg;
  endfunction

  task automatic run_phase(input int unsigned src_idle, input int unsigned snk_idle);
    in_item_t msg;
    sender_idle   = src_idle;
    receiver_idle = snk_idle;
    repeat (ItemsPerPhase) begin
      msg = make_message();
      send_message(msg.status_byte, msg.data_one, msg.data_two);
    end
    // hold off until the block has drained
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("midi_channel_message_note_tracker_core_test: FAIL");
    $finish;
  end

  initial begin
    sender_idle       = 0;
    receiver_idle     = 0;
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.status_byte = '0;
    in_if.data_one    = '0;
    in_if.data_two    = '0;
    out_if.ready      = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_message({StatusNoteOn, 4'h0}, 7'd0, 7'd127);
    send_message({StatusNoteOn, 4'h0}, 7'd0, 7'd1);
    send_message({StatusNoteOn, 4'h0}, 7'd0, 7'd0);
    send_message({StatusNoteOff, 4'h0}, 7'd0, 7'd127);
    send_message({StatusNoteOn, 4'hF}, 7'd127, 7'd64);
    send_message({StatusNoteOff, 4'hF}, 7'd127, 7'd0);
    send_message({StatusNoteOn, 4'h3}, 7'd5, 7'd100);
    send_message({StatusKeyPress, 4'h3}, 7'd5, 7'd127);
    send_message({StatusKeyPress, 4'hF}, 7'd127, 7'd0);
    send_message({StatusControl, 4'h1}, 7'd127, 7'd0);
    send_message({StatusControl, 4'h2}, 7'd0, 7'd127);
    send_message({StatusProgram, 4'hE}, 7'd127, 7'd127);
    send_message({StatusProgram, 4'h0}, 7'd0, 7'd0);
    send_message({StatusChanPress, 4'h7}, 7'd127, 7'd127);
    send_message({StatusBend, 4'h9}, 7'd0, 7'd127);
    send_message({StatusBend, 4'h6}, 7'd127, 7'd0);
    send_message(8'h00, 7'd127, 7'd127);
    send_message(8'h7F, 7'd127, 7'd127);
    send_message(8'hF0, 7'd0, 7'd0);
    send_message(8'hFF, 7'd127, 7'd127);
    send_message(8'h3A, 7'd85, 7'd42);
    send_message({StatusNoteOff, 4'h3}, 7'd5, 7'd0);
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);

    run_phase(16, 65);
    run_phase(65, 16);
    run_phase(0, 0);

    repeat (8) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("midi_channel_message_note_tracker_core_test: PASS");
    end else begin
      $display("midi_channel_message_note_tracker_core_test: FAIL");
    end
    $finish;
  end

endmodule
